// ===== src/tms_pkg.sv =====
// Shared types and constants for the trimmed-mean sampler.
// It has no dependencies. The top level and its checker both use it.
package tms_pkg;

  // Width of one converter sample and of one average.
  localparam int unsigned SampleW = 12;
  // Sum width: room for up to 64 full-scale samples without wrapping.
  localparam int unsigned SumW    = SampleW + 6;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [SumW-1:0]    sum_t;

endpackage

// ===== src/trimmed_mean_sampler_top.sv =====
// Trimmed-mean sampler: frames of SAMPLES samples in, one average out per frame.
// Throughput is one item per cycle while no held average stalls the input.
// Each frame then passes through its totals, the trimmed sum and the reciprocal multiply.
// The multiply feeds the output register.
// rst_ni is asynchronous and active low. It clears the frame state and all pipeline valids.
// Depends on tms_pkg.
module trimmed_mean_sampler_top #(
  parameter int unsigned SAMPLES = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tms_pkg::sample_t sample_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tms_pkg::sample_t average_o
);

  // The frame counter only has to reach SAMPLES-1.
  localparam int unsigned CntW = $clog2(SAMPLES);
  localparam int unsigned Div  = SAMPLES - 2;

  // Division by the constant Div is a multiply by a rounded-up reciprocal.
  // With RecipK = SumW + ceil(log2(Div)), the error of RecipM stays below
  // 2^(RecipK-SumW). That makes the truncated quotient exact for every
  // SumW-bit numerator.
  localparam int unsigned RecipK = tms_pkg::SumW + $clog2(Div);
  localparam logic [63:0] RecipWide =
    ((64'd1 << RecipK) + 64'(Div) - 64'd1) / 64'(Div);
  localparam logic [tms_pkg::SumW:0] RecipM = RecipWide[tms_pkg::SumW:0];
  localparam int unsigned ProdW = 2 * tms_pkg::SumW + 1;

  // The whole pipeline moves together. It holds only while a finished average
  // sits in the output register and the receiver stalls.
  logic advance;
  logic accept;
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  // ---------------------------------------------------------------------
  // Running frame state.
  // ---------------------------------------------------------------------
  logic [CntW-1:0]  count_q, count_d;
  tms_pkg::sample_t min_q, min_d;
  tms_pkg::sample_t max_q, max_d;
  tms_pkg::sum_t    sum_q, sum_d;
  logic             last_item;

  assign last_item = (count_q == CntW'(SAMPLES - 1));

  // These are the state values once the current item is included. They also
  // serve as the frame totals when the item closes the frame.
  always_comb begin
    if (count_q == '0) begin
      min_d = sample_i;
      max_d = sample_i;
      sum_d = tms_pkg::SumW'(sample_i);
    end else begin
      min_d = (sample_i < min_q) ? sample_i : min_q;
      max_d = (sample_i > max_q) ? sample_i : max_q;
      sum_d = sum_q + tms_pkg::SumW'(sample_i);
    end
    count_d = count_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= '0;
      max_q   <= '0;
      sum_q   <= '0;
    end else if (accept) begin
      if (last_item) begin
        // Closing the frame clears everything for the next frame.
        count_q <= '0;
        min_q   <= '0;
        max_q   <= '0;
        sum_q   <= '0;
      end else begin
        count_q <= count_d;
        min_q   <= min_d;
        max_q   <= max_d;
        sum_q   <= sum_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: the totals of the frame that just closed.
  // ---------------------------------------------------------------------
  logic             tot_valid_q;
  tms_pkg::sample_t tot_min_q, tot_max_q;
  tms_pkg::sum_t    tot_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_valid_q <= 1'b0;
    end else if (advance) begin
      tot_valid_q <= accept && last_item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_item) begin
      tot_min_q <= min_d;
      tot_max_q <= max_d;
      tot_sum_q <= sum_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: drop one minimum and one maximum. When all samples are equal,
  // the average is simply that value.
  // ---------------------------------------------------------------------
  logic             rest_valid_q;
  logic             all_equal_q;
  tms_pkg::sample_t equal_val_q;
  tms_pkg::sum_t    rest_q;
  tms_pkg::sum_t    drop;
  tms_pkg::sum_t    rest_d;

  always_comb begin
    drop   = tms_pkg::SumW'(tot_min_q) + tms_pkg::SumW'(tot_max_q);
    rest_d = (tot_sum_q >= drop) ? (tot_sum_q - drop) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_valid_q <= 1'b0;
    end else if (advance) begin
      rest_valid_q <= tot_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && tot_valid_q) begin
      all_equal_q <= (tot_max_q == tot_min_q);
      equal_val_q <= tot_max_q;
      rest_q      <= rest_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: the reciprocal multiply feeds the output register.
  // ---------------------------------------------------------------------
  logic [ProdW-1:0] prod;
  tms_pkg::sample_t quot;
  logic             out_valid_q;
  tms_pkg::sample_t average_q;

  assign prod = ProdW'(rest_q) * ProdW'(RecipM);
  assign quot = prod[RecipK +: tms_pkg::SampleW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= rest_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && rest_valid_q) begin
      average_q <= all_equal_q ? equal_val_q : quot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;

endmodule

// ===== src/tms_checker.sv =====
// Port-level checks for the trimmed-mean sampler, plus the bind that attaches them.
// Depends on tms_pkg and on trimmed_mean_sampler_top.
module tms_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input tms_pkg::sample_t sample_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input tms_pkg::sample_t average_o
);

  // Reset empties the output register by the next clock edge.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("average valid during reset");

  // The input side only stalls while an average is held by a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held average");

  // A stalled average stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(average_o)))
    else $error("stalled average changed or vanished");

  // Frames span at least three items, so two averages never leave back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("averages delivered in consecutive cycles");

  // A stalled input item is held unchanged by the sender.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(sample_i)))
    else $error("stalled sample changed or vanished");

endmodule

bind trimmed_mean_sampler_top tms_checker u_tms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .sample_i    (sample_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .average_o   (average_o)
);

// ===== sim/trimmed_mean_sampler_top_test.sv =====
// Testbench for trimmed_mean_sampler_top: frames of converter samples go in and
// the one average per frame is checked against a predictor kept in this file.
// Depends on tms_pkg and the trimmed_mean_sampler_top RTL.
`timescale 1ns / 1ps

module trimmed_mean_sampler_top_test;

  // Frame length used for the instance and for the predictor.
  localparam int unsigned FrameLen   = 30;
  // Samples left once one minimum and one maximum are dropped.
  localparam int unsigned TrimDiv    = (FrameLen > 2) ? FrameLen - 2 : 1;
  localparam int unsigned SampleMax  = (1 << tms_pkg::SampleW) - 1;
  localparam int unsigned FrameCount = 53;
  // One directed frame plus the random frames.
  localparam int unsigned TotalItems = FrameLen * (FrameCount + 1);
  // Cycles with no item accepted on either side before the run is declared hung.
  localparam int unsigned HangLimit  = 6000;
  // Length of the one long output hold-off that backs the block up.
  localparam int unsigned HoldOff    = 2000;
  // Cycles allowed after the last average for a stray result to show up.
  localparam int unsigned DrainCycles = 12;

  // Shapes of the frames fed in the random part.
  typedef enum logic [2:0] {
    FRAME_UNIFORM,
    FRAME_FLAT,
    FRAME_FLAT_EDGE,
    FRAME_TWO_LEVEL,
    FRAME_NARROW,
    FRAME_PINNED
  } frame_kind_e;

  // One sample waiting to be sent, with the idle cycles that follow it.
  typedef struct {
    tms_pkg::sample_t value;
    int unsigned      gap;
  } pending_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid    = 1'b0;
  logic             out_stall   = 1'b0;
  tms_pkg::sample_t sample      = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  tms_pkg::sample_t average_o;

  pending_t         sample_q[$];
  tms_pkg::sample_t average_q[$];
  int unsigned error_count  = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  int unsigned sent_count   = 0;

  // Predictor state: a copy of the frame accumulators inside the block.
  logic [5:0]       frame_count = '0;
  tms_pkg::sample_t frame_min   = '0;
  tms_pkg::sample_t frame_max   = '0;
  tms_pkg::sum_t    frame_sum   = '0;

  trimmed_mean_sampler_top #(
    .SAMPLES(FrameLen)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .sample_i   (sample),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .average_o  (average_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Folds one accepted sample into the frame. When the sample closes the frame,
  // the trimmed average is returned through avg and the function returns 1.
  // A frame whose samples are all equal averages to that value; otherwise one
  // minimum and one maximum come off the sum before the truncating divide.
  function automatic bit fold_sample(input tms_pkg::sample_t s,
                                     output tms_pkg::sample_t avg);
    tms_pkg::sum_t dropped;
    tms_pkg::sum_t trimmed;
    avg = '0;
    if (frame_count == 0) begin
      frame_min = s;
      frame_max = s;
    end else begin
      if (s > frame_max) frame_max = s;
      if (s < frame_min) frame_min = s;
    end
    frame_sum = frame_sum + tms_pkg::sum_t'(s);
    if (frame_count + 1 < FrameLen) begin
      frame_count = frame_count + 6'd1;
      return 1'b0;
    end
    if (frame_max == frame_min) begin
      avg = frame_max;
    end else begin
      dropped = tms_pkg::sum_t'(frame_min) + tms_pkg::sum_t'(frame_max);
      trimmed = (frame_sum >= dropped) ? frame_sum - dropped : '0;
      avg     = tms_pkg::sample_t'(trimmed / TrimDiv);
    end
    frame_count = '0;
    frame_min   = '0;
    frame_max   = '0;
    frame_sum   = '0;
    return 1'b1;
  endfunction

  // Idle cycles after one item: mostly none or a few, now and then a long gap.
  // Quiet frames send back to back.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Queues one whole frame of the given shape. The pinned shape forces a
  // full-scale low, and a high unless both fall on one position, and repeats
  // the extremes, so that only one copy of each must come off the sum.
  task automatic queue_frame(input frame_kind_e kind, input bit quiet);
    pending_t    item;
    int unsigned a;
    int unsigned b;
    int unsigned lo_pos;
    int unsigned hi_pos;
    int unsigned v;
    a      = $urandom_range(0, SampleMax);
    b      = $urandom_range(0, SampleMax);
    lo_pos = $urandom_range(0, FrameLen - 1);
    hi_pos = $urandom_range(0, FrameLen - 1);
    for (int unsigned i = 0; i < FrameLen; i++) begin
      case (kind)
        FRAME_FLAT:      v = a;
        FRAME_FLAT_EDGE: v = a[0] ? SampleMax : 0;
        FRAME_TWO_LEVEL: v = $urandom_range(0, 1) ? a : b;
        FRAME_NARROW: begin
          if (a > SampleMax - 7) v = SampleMax - $urandom_range(0, 7);
          else v = a + $urandom_range(0, 7);
        end
        FRAME_PINNED: begin
          if (i == lo_pos) v = 0;
          else if (i == hi_pos) v = SampleMax;
          else begin
            case ($urandom_range(0, 3))
              0:       v = 0;
              1:       v = SampleMax;
              default: v = $urandom_range(0, SampleMax);
            endcase
          end
        end
        default:         v = $urandom_range(0, SampleMax);
      endcase
      item.value = tms_pkg::sample_t'(v);
      item.gap   = pick_gap(quiet);
      sample_q.push_back(item);
    end
  endtask

  // Sender. A stalled item is held as it is; after an accepted item the
  // driver sits out that item's gap, then offers the next sample from the
  // queue. Every accepted sample goes through the predictor right away.
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    pending_t         nxt;
    tms_pkg::sample_t avg;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      sample   <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        sent_count++;
        if (fold_sample(sample, avg)) average_q.push_back(avg);
      end
      if (in_valid && in_stall_o) begin
        // Keep offering the same item.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        nxt = sample_q.pop_front();
        in_valid <= 1'b1;
        sample   <= nxt.value;
        gap_left = nxt.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. Each accepted average is compared with the oldest expected one.
  // The stall pattern alternates runs of readiness with stall stretches, most
  // of them short. Once five averages have come, the receiver holds off for
  // a long stretch so that the pipeline fills and the block stalls its input.
  int unsigned run_left   = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          held_off   = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    tms_pkg::sample_t want;
    logic             stall_next;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      run_left   = 0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (average_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected average %0d with none expected", $time, average_o);
        end else begin
          want = average_q.pop_front();
          if (average_o !== want) begin
            error_count++;
            $display("%0t: average mismatch, expected %0d, actual %0d",
                     $time, want, average_o);
          end
        end
      end
      if (!held_off && results_seen == 5) begin
        held_off  = 1'b1;
        hold_left = HoldOff;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        stall_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else begin
        // Start a new pattern: a ready run followed by a stall stretch.
        run_left   = ($urandom_range(0, 99) < 15) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 8);
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= HangLimit) begin
          $display("%0t: no item moved for %0d cycles", $time, HangLimit);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    pending_t    item;
    int unsigned r;
    bit          quiet;
    frame_kind_e kind;

    // Directed frame: every sample at full scale. This is the all-equal case
    // and also the largest sum a frame can build.
    for (int unsigned i = 0; i < FrameLen; i++) begin
      item.value = tms_pkg::sample_t'(SampleMax);
      item.gap   = pick_gap(1'b0);
      sample_q.push_back(item);
    end

    // Random frames of mixed shapes; about one in four is sent back to back.
    for (int unsigned f = 0; f < FrameCount; f++) begin
      r     = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 3) == 0);
      case (r)
        5:       kind = FRAME_FLAT;
        6:       kind = FRAME_FLAT_EDGE;
        7:       kind = FRAME_TWO_LEVEL;
        8:       kind = FRAME_NARROW;
        9:       kind = FRAME_PINNED;
        default: kind = FRAME_UNIFORM;
      endcase
      queue_frame(kind, quiet);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every sample to be taken, then for every average to arrive.
    while (sent_count < TotalItems) @(posedge clk_i);
    while (average_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0 && average_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
